@@ rtl/lsi_pkg.sv @@
// Shared widths, codes and register map of the line segment intersection block.
package lsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int TOL_W       = 16;

  // Widths of the exact intermediates.
  localparam int DIFF_W = COORD_WIDTH + 1;              // coordinate difference
  localparam int PROD_W = 2 * DIFF_W;                   // product of two differences
  localparam int N_W    = PROD_W + 1;                   // n, nt, ns
  localparam int LO_W   = N_W - DIFF_W;                 // low split of nt for nt*c
  localparam int XN_W   = N_W + DIFF_W;                 // nt*c3, nt*c4
  localparam int NUM_W  = N_W + ((DIFF_W > FRAC_BITS) ? DIFF_W : FRAC_BITS);
  localparam int D_W    = N_W;                          // |n|
  localparam int QW     = COORD_WIDTH + 2;              // quotient magnitude bits
  localparam int RW_A   = NUM_W + 2;
  localparam int RW_B   = D_W + 1 + QW;
  localparam int RW     = ((RW_A > RW_B) ? RW_A : RW_B) + 1;  // divider remainder
  localparam int PC_W   = N_W + FRAC_BITS + TOL_W;      // slope test compare
  localparam int RC_W   = QW + FRAC_BITS + 3;           // parameter range compare

  // Stream and register port widths
  localparam int IN_DATA_W  = 8 * COORD_WIDTH;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 4 * COORD_WIDTH;
  localparam int OUT_USER_W = 5;
  localparam int ST_W       = 3;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // Operations
  localparam logic [1:0] OP_LINES    = 2'd0;
  localparam logic [1:0] OP_SEGS     = 2'd1;
  localparam logic [1:0] OP_SEG_LINE = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_VERT  = 3'd1;
  localparam logic [ST_W-1:0] ST_PAR   = 3'd2;
  localparam logic [ST_W-1:0] ST_TINY  = 3'd3;
  localparam logic [ST_W-1:0] ST_T_OUT = 3'd4;
  localparam logic [ST_W-1:0] ST_S_OUT = 3'd5;

  // Register index, taken from paddr[2]
  localparam logic REG_ZERO_TOL  = 1'b0;
  localparam logic REG_PARAM_TOL = 1'b1;

endpackage

@@ rtl/line_segment_intersection.sv @@
// Top level: 2-D line / segment intersection pipeline with APB tolerance registers.
//
//  channel  | dir | handshake                 | contents
//  ---------+-----+---------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready      | tdata p_x..b_y, tuser operation
//  m_axis   | out | m_axis_tvalid/tready      | tdata point_x..param_s, tuser found/status/sat
//  apb      | in  | psel/penable/pwrite/pready| zero_tolerance @0x0, param_tolerance @0x4
//
//  One request enters per clock while s_axis_tready_o is high. At 32-bit coordinates the pipe has
//  six arithmetic stages, QW+1 = 35 divider stages (a rounding setup stage, then one quotient
//  bit each), one sum stage and the output register.
//  Reset clears the valid bits and both tolerance registers.
//  A stall on m_axis freezes the pipe only once the skid entry is full, so two
//  finished results may wait while s_axis_tready_o is still high for one of them.
module line_segment_intersection import lsi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // p_x, p_y, q_x, q_y, a_x, a_y, b_x, b_y (COORD_WIDTH bits each, LSB first)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // operation
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // point_x, point_y, param_t, param_s (LSB first)
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // found, status[2:0], saturated (LSB first)
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  localparam int CW      = COORD_WIDTH;
  localparam int DIV_LAT = QW + 1;
  localparam int DV_T = 0, DV_S = 1, DV_X = 2, DV_Y = 3;

  typedef struct packed {
    logic [1:0]             op;
    logic [ST_W-1:0]        rej;
    logic signed [CW-1:0]   px;
    logic signed [CW-1:0]   py;
  } side_t;

  typedef struct packed {
    logic                   found;
    logic [ST_W-1:0]        status;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [CW-1:0]   t;
    logic signed [CW-1:0]   s;
    logic                   sat;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0]   val;
    logic                   clip;
  } sat_t;

  localparam logic signed [QW+1:0] SMAX = (QW+2)'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [QW+1:0] SMIN = -SMAX - 1;
  localparam logic signed [RC_W-1:0] ONE_Q = RC_W'(1) << FRAC_BITS;

  function automatic logic signed [DIFF_W-1:0] dif(input logic [CW-1:0] a,
                                                    input logic [CW-1:0] b);
    return {a[CW-1], a} - {b[CW-1], b};
  endfunction

  function automatic sat_t clamp(input logic signed [QW+1:0] v, input logic ovf,
                                 input logic neg);
    sat_t r;
    r.clip = 1'b1;
    if (ovf)            r.val = neg ? CW'(SMIN) : CW'(SMAX);
    else if (v > SMAX)  r.val = CW'(SMAX);
    else if (v < SMIN)  r.val = CW'(SMIN);
    else begin
      r.val  = CW'(v);
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // outside [-pt, 1 + pt], on the rounded value before clamping
  function automatic logic out_rng(input logic signed [QW:0] v, input logic ovf,
                                   input logic [TOL_W-1:0] pt);
    logic signed [RC_W-1:0] vv, ptv;
    vv  = RC_W'(v);
    ptv = RC_W'($signed({1'b0, pt}));
    return ovf || (vv < -ptv) || (vv > ONE_Q + ptv);
  endfunction

  // ---------------- configuration ----------------
  logic [TOL_W-1:0] zt_q, pt_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_PARAM_TOL) ? APB_DW'(pt_q) : APB_DW'(zt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zt_q <= '0;
      pt_q <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == REG_ZERO_TOL) zt_q <= pwdata[TOL_W-1:0];
      else                          pt_q <= pwdata[TOL_W-1:0];
    end
  end

  // ---------------- flow control ----------------
  logic en;            // whole pipe advances while the skid entry is free
  logic out_v_q, skid_v_q;
  out_t out_q, skid_q, item_d;

  assign en              = ~skid_v_q;
  assign s_axis_tready_o = en;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, p1_v_q;
  logic dv_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) dv_q[i] <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      dv_q[0] <= s6_v_q;
      for (int i = 1; i < DIV_LAT; i++) dv_q[i] <= dv_q[i-1];
      p1_v_q <= dv_q[DIV_LAT-1];
    end
  end

  // ---------------- S1: differences ----------------
  logic [1:0]                s1_op_q;
  logic signed [CW-1:0]      s1_px_q, s1_py_q;
  logic signed [DIFF_W-1:0]  s1_c1_q, s1_c2_q, s1_c3_q, s1_c4_q, s1_c5_q, s1_c6_q;
  logic [CW-1:0]             in_px, in_py, in_qx, in_qy, in_ax, in_ay, in_bx, in_by;

  assign in_px = s_axis_tdata_i[0*CW +: CW];
  assign in_py = s_axis_tdata_i[1*CW +: CW];
  assign in_qx = s_axis_tdata_i[2*CW +: CW];
  assign in_qy = s_axis_tdata_i[3*CW +: CW];
  assign in_ax = s_axis_tdata_i[4*CW +: CW];
  assign in_ay = s_axis_tdata_i[5*CW +: CW];
  assign in_bx = s_axis_tdata_i[6*CW +: CW];
  assign in_by = s_axis_tdata_i[7*CW +: CW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= s_axis_tuser_i;
      s1_px_q <= in_px;
      s1_py_q <= in_py;
      s1_c1_q <= dif(in_bx, in_ax);
      s1_c2_q <= dif(in_by, in_ay);
      s1_c3_q <= dif(in_qx, in_px);
      s1_c4_q <= dif(in_qy, in_py);
      s1_c5_q <= dif(in_px, in_ax);
      s1_c6_q <= dif(in_py, in_ay);
    end
  end

  // ---------------- S2: products, vertical test ----------------
  logic [1:0]               s2_op_q;
  logic signed [CW-1:0]     s2_px_q, s2_py_q;
  logic signed [DIFF_W-1:0] s2_c3_q, s2_c4_q;
  logic signed [PROD_W-1:0] s2_p23_q, s2_p14_q, s2_p61_q, s2_p52_q;
  logic signed [PROD_W-1:0] s2_p63_q, s2_p54_q, s2_p13_q;
  logic                     s2_vert_q;
  logic [DIFF_W-1:0]        ac1, ac3;

  assign ac1 = s1_c1_q[DIFF_W-1] ? -s1_c1_q : s1_c1_q;
  assign ac3 = s1_c3_q[DIFF_W-1] ? -s1_c3_q : s1_c3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q   <= s1_op_q;
      s2_px_q   <= s1_px_q;
      s2_py_q   <= s1_py_q;
      s2_c3_q   <= s1_c3_q;
      s2_c4_q   <= s1_c4_q;
      s2_p23_q  <= s1_c2_q * s1_c3_q;
      s2_p14_q  <= s1_c1_q * s1_c4_q;
      s2_p61_q  <= s1_c6_q * s1_c1_q;
      s2_p52_q  <= s1_c5_q * s1_c2_q;
      s2_p63_q  <= s1_c6_q * s1_c3_q;
      s2_p54_q  <= s1_c5_q * s1_c4_q;
      s2_p13_q  <= s1_c1_q * s1_c3_q;
      s2_vert_q <= (ac1 <= DIFF_W'(zt_q)) && (ac3 <= DIFF_W'(zt_q));
    end
  end

  // ---------------- S3: denominator and numerators ----------------
  logic [1:0]               s3_op_q;
  logic signed [CW-1:0]     s3_px_q, s3_py_q;
  logic signed [DIFF_W-1:0] s3_c3_q, s3_c4_q;
  logic signed [N_W-1:0]    s3_n_q, s3_nt_q, s3_ns_q;
  logic [PROD_W-1:0]        s3_ap13_q;
  logic                     s3_vert_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_op_q   <= s2_op_q;
      s3_px_q   <= s2_px_q;
      s3_py_q   <= s2_py_q;
      s3_c3_q   <= s2_c3_q;
      s3_c4_q   <= s2_c4_q;
      s3_n_q    <= N_W'(s2_p23_q) - N_W'(s2_p14_q);
      s3_nt_q   <= N_W'(s2_p61_q) - N_W'(s2_p52_q);
      s3_ns_q   <= N_W'(s2_p63_q) - N_W'(s2_p54_q);
      s3_ap13_q <= s2_p13_q[PROD_W-1] ? -s2_p13_q : s2_p13_q;
      s3_vert_q <= s2_vert_q;
    end
  end

  // ---------------- S4: |n|, slope product, nt*c split ----------------
  logic [1:0]                 s4_op_q;
  logic signed [CW-1:0]       s4_px_q, s4_py_q;
  logic signed [N_W-1:0]      s4_nt_q, s4_ns_q;
  logic                       s4_nneg_q, s4_vert_q;
  logic [N_W-1:0]             s4_an_q;
  logic [PROD_W+TOL_W-1:0]    s4_ztp_q;
  logic signed [PROD_W-1:0]   s4_xh_q, s4_yh_q;
  logic signed [LO_W+DIFF_W:0] s4_xl_q, s4_yl_q;
  logic signed [DIFF_W-1:0]   nt_hi;
  logic signed [LO_W:0]       nt_lo;

  assign nt_hi = s3_nt_q[N_W-1:LO_W];
  assign nt_lo = $signed({1'b0, s3_nt_q[LO_W-1:0]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_op_q   <= s3_op_q;
      s4_px_q   <= s3_px_q;
      s4_py_q   <= s3_py_q;
      s4_nt_q   <= s3_nt_q;
      s4_ns_q   <= s3_ns_q;
      s4_nneg_q <= s3_n_q[N_W-1];
      s4_vert_q <= s3_vert_q;
      s4_an_q   <= s3_n_q[N_W-1] ? -s3_n_q : s3_n_q;
      s4_ztp_q  <= s3_ap13_q * zt_q;
      s4_xh_q   <= nt_hi * s3_c3_q;
      s4_yh_q   <= nt_hi * s3_c4_q;
      s4_xl_q   <= nt_lo * s3_c3_q;
      s4_yl_q   <= nt_lo * s3_c4_q;
    end
  end

  // ---------------- S5: reject tests, nt*c sums ----------------
  side_t                 s5_side_q;
  logic signed [N_W-1:0] s5_nt_q, s5_ns_q;
  logic signed [XN_W-1:0] s5_xn_q, s5_yn_q;
  logic                  s5_nneg_q;
  logic [N_W-1:0]        s5_an_q;
  logic                  par, tiny;
  logic [ST_W-1:0]       rej;

  assign par  = (PC_W'(s4_an_q) << FRAC_BITS) <= PC_W'(s4_ztp_q);
  assign tiny = s4_an_q <= (N_W'(zt_q) << FRAC_BITS);
  assign rej  = s4_vert_q ? ST_VERT : par ? ST_PAR : tiny ? ST_TINY : ST_OK;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_side_q.op  <= s4_op_q;
      s5_side_q.rej <= rej;
      s5_side_q.px  <= s4_px_q;
      s5_side_q.py  <= s4_py_q;
      s5_nt_q       <= s4_nt_q;
      s5_ns_q       <= s4_ns_q;
      s5_nneg_q     <= s4_nneg_q;
      s5_an_q       <= s4_an_q;
      s5_xn_q       <= (XN_W'(s4_xh_q) <<< LO_W) + XN_W'(s4_xl_q);
      s5_yn_q       <= (XN_W'(s4_yh_q) <<< LO_W) + XN_W'(s4_yl_q);
    end
  end

  // ---------------- S6: divider operands ----------------
  side_t            s6_side_q;
  logic [NUM_W-1:0] s6_num_q [4];
  logic             s6_neg_q [4];
  logic [D_W-1:0]   s6_den_q;
  logic [N_W-1:0]   ant, ans;
  logic [XN_W-1:0]  axn, ayn;

  assign ant = s5_nt_q[N_W-1]  ? -s5_nt_q : s5_nt_q;
  assign ans = s5_ns_q[N_W-1]  ? -s5_ns_q : s5_ns_q;
  assign axn = s5_xn_q[XN_W-1] ? -s5_xn_q : s5_xn_q;
  assign ayn = s5_yn_q[XN_W-1] ? -s5_yn_q : s5_yn_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_side_q      <= s5_side_q;
      s6_den_q       <= s5_an_q;
      s6_num_q[DV_T] <= NUM_W'(ant) << FRAC_BITS;
      s6_num_q[DV_S] <= NUM_W'(ans) << FRAC_BITS;
      s6_num_q[DV_X] <= NUM_W'(axn);
      s6_num_q[DV_Y] <= NUM_W'(ayn);
      s6_neg_q[DV_T] <= s5_nt_q[N_W-1]  ^ s5_nneg_q;
      s6_neg_q[DV_S] <= s5_ns_q[N_W-1]  ^ s5_nneg_q;
      s6_neg_q[DV_X] <= s5_xn_q[XN_W-1] ^ s5_nneg_q;
      s6_neg_q[DV_Y] <= s5_yn_q[XN_W-1] ^ s5_nneg_q;
    end
  end

  // ---------------- dividers, side info runs alongside ----------------
  logic signed [QW:0] quo [4];
  logic               qovf [4];
  logic               qneg [4];
  side_t              dside_q [DIV_LAT];

  for (genvar g = 0; g < 4; g++) begin : g_div
    lsi_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .neg_i (s6_neg_q[g]),
      .num_i (s6_num_q[g]),
      .den_i (s6_den_q),
      .quo_o (quo[g]),
      .ovf_o (qovf[g]),
      .neg_o (qneg[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dside_q[0] <= s6_side_q;
      for (int i = 1; i < DIV_LAT; i++) dside_q[i] <= dside_q[i-1];
    end
  end

  // ---------------- P1: S = P + displacement ----------------
  side_t                p1_side_q;
  logic signed [QW:0]   p1_qt_q, p1_qs_q;
  logic signed [QW+1:0] p1_xs_q, p1_ys_q;
  logic                 p1_ovf_q [4];
  logic                 p1_neg_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_side_q <= dside_q[DIV_LAT-1];
      p1_qt_q   <= quo[DV_T];
      p1_qs_q   <= quo[DV_S];
      p1_xs_q   <= (QW+2)'(dside_q[DIV_LAT-1].px) + (QW+2)'(quo[DV_X]);
      p1_ys_q   <= (QW+2)'(dside_q[DIV_LAT-1].py) + (QW+2)'(quo[DV_Y]);
      for (int i = 0; i < 4; i++) begin
        p1_ovf_q[i] <= qovf[i];
        p1_neg_q[i] <= qneg[i];
      end
    end
  end

  // ---------------- P2: clamp, range checks, status ----------------
  sat_t            cx, cy, ct, cs;
  logic            t_out, s_out;
  logic [ST_W-1:0] st;

  assign cx = clamp(p1_xs_q, p1_ovf_q[DV_X], p1_neg_q[DV_X]);
  assign cy = clamp(p1_ys_q, p1_ovf_q[DV_Y], p1_neg_q[DV_Y]);
  assign ct = clamp((QW+2)'(p1_qt_q), p1_ovf_q[DV_T], p1_neg_q[DV_T]);
  assign cs = clamp((QW+2)'(p1_qs_q), p1_ovf_q[DV_S], p1_neg_q[DV_S]);
  assign t_out = out_rng(p1_qt_q, p1_ovf_q[DV_T], pt_q);
  assign s_out = out_rng(p1_qs_q, p1_ovf_q[DV_S], pt_q);

  always_comb begin
    st = ST_OK;
    if ((p1_side_q.op == OP_SEGS || p1_side_q.op == OP_SEG_LINE) && t_out) begin
      st = ST_T_OUT;
    end else if (p1_side_q.op == OP_SEGS && s_out) begin
      st = ST_S_OUT;
    end
    if (p1_side_q.rej != ST_OK) begin
      item_d        = '0;
      item_d.status = p1_side_q.rej;
    end else begin
      item_d.found  = (st == ST_OK);
      item_d.status = st;
      item_d.x      = cx.val;
      item_d.y      = cy.val;
      item_d.t      = ct.val;
      item_d.s      = cs.val;
      item_d.sat    = cx.clip | cy.clip | ct.clip | cs.clip;
    end
  end

  // ---------------- output register with skid entry ----------------
  logic push, pop;

  assign push = en & p1_v_q;
  assign pop  = out_v_q & m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) skid_v_q <= 1'b0;
    end else if (!out_v_q || pop) begin
      out_v_q <= push;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) out_q <= skid_q;
    end else if (!out_v_q || pop) begin
      out_q <= item_d;
    end else begin
      skid_q <= item_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.s, out_q.t, out_q.y, out_q.x};
  assign m_axis_tuser_o  = {out_q.sat, out_q.status, out_q.found};

endmodule

@@ rtl/lsi_div.sv @@
// Pipelined restoring divider, rounds to nearest with ties away from zero.
module lsi_div import lsi_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                neg_i,
  input  logic [NUM_W-1:0]    num_i,   // |numerator|
  input  logic [D_W-1:0]      den_i,   // |denominator|
  output logic signed [QW:0]  quo_o,
  output logic                ovf_o,   // |quotient| >= 2^QW
  output logic                neg_o
);

  logic [RW-1:0] rem_q [QW];
  logic [RW-1:0] dd_q  [QW];
  logic [QW-1:0] quo_q [QW+1];
  logic          neg_q [QW+1];
  logic          ovf_q [QW+1];

  logic [RW-1:0] rem0_d, dd0_d;

  // round: floor((2a + d) / 2d)
  assign rem0_d = (RW'(num_i) << 1) + RW'(den_i);
  assign dd0_d  = RW'(den_i) << 1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0_d;
      dd_q[0]  <= dd0_d;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      ovf_q[0] <= rem0_d >= (dd0_d << QW);
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [RW-1:0] sub;
    logic          take;

    assign sub  = dd_q[k-1] << B;
    assign take = rem_q[k-1] >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= quo_q[k-1] | (take ? (QW'(1) << B) : '0);
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? rem_q[k-1] - sub : rem_q[k-1];
          dd_q[k]  <= dd_q[k-1];
        end
      end
    end
  end

  assign quo_o = neg_q[QW] ? -$signed({1'b0, quo_q[QW]}) : $signed({1'b0, quo_q[QW]});
  assign ovf_o = ovf_q[QW];
  assign neg_o = neg_q[QW];

endmodule

@@ rtl/lsi_checker.sv @@
// Port-level assertions for the intersection block, bound to the top level.
module lsi_checker import lsi_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_USER_W-1:0] m_axis_tuser_o
);

  logic [ST_W-1:0] st;
  logic            rejected;

  assign st       = m_axis_tuser_o[ST_W:1];
  assign rejected = (st == ST_VERT) || (st == ST_PAR) || (st == ST_TINY);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[0] == (st == ST_OK)))
    else $error("found disagrees with status");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && rejected |->
      (m_axis_tdata_o == '0) && !m_axis_tuser_o[OUT_USER_W-1])
    else $error("rejected result carries data");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output");

endmodule

bind line_segment_intersection lsi_checker u_lsi_checker (.*);
